[rtl/jbt_pkg.sv]
// ----------------------------------------------------------------------------
// jbt_pkg
// Shared types and constants of the JSON byte tokenizer: word layouts,
// token kinds, error codes and the character codes the lexer decodes.
// ----------------------------------------------------------------------------
`default_nettype none

package jbt_pkg;

  // Token kinds
  localparam logic [3:0] KIND_LBRACE  = 4'd0;
  localparam logic [3:0] KIND_RBRACE  = 4'd1;
  localparam logic [3:0] KIND_LBRACK  = 4'd2;
  localparam logic [3:0] KIND_RBRACK  = 4'd3;
  localparam logic [3:0] KIND_COMMA   = 4'd4;
  localparam logic [3:0] KIND_COLON   = 4'd5;
  localparam logic [3:0] KIND_PERIOD  = 4'd6;
  localparam logic [3:0] KIND_STRING  = 4'd7;
  localparam logic [3:0] KIND_NUMBER  = 4'd8;
  localparam logic [3:0] KIND_KEYWORD = 4'd9;
  localparam logic [3:0] KIND_END     = 4'd10;

  // Error codes
  localparam logic [3:0] ERR_NONE       = 4'd0;
  localparam logic [3:0] ERR_BAD_CHAR   = 4'd1;
  localparam logic [3:0] ERR_END_ESC    = 4'd2;
  localparam logic [3:0] ERR_OPEN_STR   = 4'd3;
  localparam logic [3:0] ERR_BARE_MINUS = 4'd4;
  localparam logic [3:0] ERR_LEAD_ZERO  = 4'd5;
  localparam logic [3:0] ERR_EMPTY_FRAC = 4'd6;
  localparam logic [3:0] ERR_EMPTY_EXP  = 4'd7;
  localparam logic [3:0] ERR_TOO_LONG   = 4'd8;

  // Character codes
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;

  localparam logic MODE_DATA = 1'b0;
  localparam logic MODE_END  = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] char_in;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [15:0] value_start;
    logic [15:0] value_length;
    logic [3:0]  error_code;
    logic        last_of_run;
  } tok_word_t;

  // Results of one accepted byte: how many, and up to two words in order
  typedef struct packed {
    logic [1:0] count;
    tok_word_t  first;
    tok_word_t  second;
  } push_t;

endpackage

`default_nettype wire

[rtl/jbt_stream_if.sv]
// ----------------------------------------------------------------------------
// jbt_stream_if
// Valid/ready channel carrying one payload word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface jbt_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/jbt_lexer.sv]
// ----------------------------------------------------------------------------
// jbt_lexer
// Lexer state, byte position and token start; decodes one word per cycle
// while take is high, into zero, one or two result words.
// ----------------------------------------------------------------------------
`default_nettype none

module jbt_lexer #(
  parameter int unsigned MAX_BYTES = 65535
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  jbt_pkg::in_word_t word,
  output jbt_pkg::push_t   push
);
  import jbt_pkg::*;

  localparam int POS_W = $clog2(longint'(MAX_BYTES) + 1);
  localparam logic [POS_W-1:0] MAX_POS = POS_W'(longint'(MAX_BYTES));

  typedef enum logic [3:0] {
    ST_IDLE, ST_STR, ST_STR_ESC, ST_MINUS, ST_ZERO, ST_INT, ST_DOT,
    ST_FRAC, ST_EXPMARK, ST_EXPSIGN, ST_EXP, ST_WORD, ST_ERR
  } lex_state_t;

  lex_state_t       state, state_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [15:0]      token_begin, token_begin_next;

  logic [POS_W+15:0] pos_ext;
  logic [15:0]       pos16;
  logic [7:0]        c;
  logic              c_digit, c_lower, c_letter, c_exp;

  // Idle-byte decode, shared by the idle state and the byte that ends a token
  logic       idle_has;
  tok_word_t  idle_res;
  lex_state_t idle_state;
  logic [15:0] idle_begin;

  tok_word_t fin_res, end_res, fail_res;
  logic [3:0] fail_code, fin_kind;
  logic [1:0] n;
  tok_word_t  r0, r1;

  assign pos_ext  = {16'b0, pos};
  assign pos16    = pos_ext[15:0];
  assign c        = word.char_in;
  assign c_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
  assign c_lower  = (c >= CH_LOW_A) && (c <= CH_LOW_Z);
  assign c_letter = c_lower || ((c >= CH_UP_A) && (c <= CH_UP_Z));
  assign c_exp    = (c == CH_LOW_E) || (c == CH_UP_E);

  always_comb begin
    idle_has   = 1'b0;
    idle_res   = '{token_kind: KIND_END, value_start: pos16, value_length: 16'd1,
                   error_code: ERR_NONE, last_of_run: 1'b0};
    idle_state = ST_IDLE;
    idle_begin = token_begin;
    case (c)
      CH_SPACE, CH_LF, CH_TAB, CH_CR: idle_has = 1'b0;
      CH_LBRACE: begin idle_has = 1'b1; idle_res.token_kind = KIND_LBRACE; end
      CH_RBRACE: begin idle_has = 1'b1; idle_res.token_kind = KIND_RBRACE; end
      CH_LBRACK: begin idle_has = 1'b1; idle_res.token_kind = KIND_LBRACK; end
      CH_RBRACK: begin idle_has = 1'b1; idle_res.token_kind = KIND_RBRACK; end
      CH_COMMA:  begin idle_has = 1'b1; idle_res.token_kind = KIND_COMMA;  end
      CH_COLON:  begin idle_has = 1'b1; idle_res.token_kind = KIND_COLON;  end
      CH_DOT:    begin idle_has = 1'b1; idle_res.token_kind = KIND_PERIOD; end
      CH_QUOTE: begin
        idle_state = ST_STR;
        idle_begin = pos16 + 16'd1;
      end
      CH_MINUS: begin
        idle_state = ST_MINUS;
        idle_begin = pos16;
      end
      CH_ZERO: begin
        idle_state = ST_ZERO;
        idle_begin = pos16;
      end
      default: begin
        if (c_digit) begin
          idle_state = ST_INT;
          idle_begin = pos16;
        end else if (c_letter) begin
          idle_state = ST_WORD;
          idle_begin = pos16;
        end else begin
          idle_has                = 1'b1;
          idle_res.value_length   = 16'd0;
          idle_res.error_code     = ERR_BAD_CHAR;
          idle_state              = ST_ERR;
        end
      end
    endcase
  end

  always_comb begin
    fin_kind  = (state == ST_WORD) ? KIND_KEYWORD : KIND_NUMBER;
    fin_res   = '{token_kind: fin_kind, value_start: token_begin,
                  value_length: pos16 - token_begin, error_code: ERR_NONE,
                  last_of_run: 1'b0};
    end_res   = '{token_kind: KIND_END, value_start: pos16, value_length: 16'd0,
                  error_code: ERR_NONE, last_of_run: 1'b0};
    fail_code = ERR_NONE;
    fail_res  = end_res;

    n                = 2'd0;
    r0               = end_res;
    r1               = end_res;
    state_next       = state;
    pos_next         = pos;
    token_begin_next = token_begin;

    if (word.mode == MODE_END) begin
      unique case (state)
        ST_ERR: n = 2'd0;
        ST_STR:                  begin n = 2'd1; fail_code = ERR_OPEN_STR;   end
        ST_STR_ESC:              begin n = 2'd1; fail_code = ERR_END_ESC;    end
        ST_MINUS:                begin n = 2'd1; fail_code = ERR_BARE_MINUS; end
        ST_DOT:                  begin n = 2'd1; fail_code = ERR_EMPTY_FRAC; end
        ST_EXPMARK, ST_EXPSIGN:  begin n = 2'd1; fail_code = ERR_EMPTY_EXP;  end
        ST_ZERO, ST_INT, ST_FRAC, ST_EXP, ST_WORD: begin
          n  = 2'd2;
          r0 = fin_res;
        end
        default: n = 2'd1;
      endcase
      fail_res.error_code = fail_code;
      if (fail_code != ERR_NONE) r0 = fail_res;
      // Return to a fresh text
      state_next       = ST_IDLE;
      pos_next         = '0;
      token_begin_next = '0;
    end else if (state == ST_ERR) begin
      n = 2'd0;
    end else if (pos == MAX_POS) begin
      n                   = 2'd1;
      fail_res.error_code = ERR_TOO_LONG;
      r0                  = fail_res;
      state_next          = ST_ERR;
    end else begin
      pos_next = pos + 1'b1;
      unique case (state)
        ST_STR: begin
          if (c == CH_BSLASH) begin
            state_next = ST_STR_ESC;
          end else if (c == CH_QUOTE) begin
            n                 = 2'd1;
            r0                = fin_res;
            r0.token_kind     = KIND_STRING;
            state_next        = ST_IDLE;
          end
        end
        ST_STR_ESC: state_next = ST_STR;
        ST_MINUS: begin
          if (c == CH_ZERO) state_next = ST_ZERO;
          else if (c_digit) state_next = ST_INT;
          else fail_code = ERR_BARE_MINUS;
        end
        ST_DOT: begin
          if (c_digit) state_next = ST_FRAC;
          else fail_code = ERR_EMPTY_FRAC;
        end
        ST_EXPMARK: begin
          if (c == CH_PLUS || c == CH_MINUS) state_next = ST_EXPSIGN;
          else if (c_digit) state_next = ST_EXP;
          else fail_code = ERR_EMPTY_EXP;
        end
        ST_EXPSIGN: begin
          if (c_digit) state_next = ST_EXP;
          else fail_code = ERR_EMPTY_EXP;
        end
        ST_ZERO, ST_INT, ST_FRAC, ST_EXP, ST_WORD: begin
          if (state == ST_ZERO && c_digit) begin
            fail_code = ERR_LEAD_ZERO;
          end else if (state == ST_WORD ? c_lower : c_digit) begin
            state_next = state;
          end else if (c == CH_DOT && (state == ST_ZERO || state == ST_INT)) begin
            state_next = ST_DOT;
          end else if (c_exp && (state == ST_ZERO || state == ST_INT ||
                                 state == ST_FRAC)) begin
            state_next = ST_EXPMARK;
          end else begin
            // Emit the token, then treat this byte as if idle
            r0               = fin_res;
            r1               = idle_res;
            n                = idle_has ? 2'd2 : 2'd1;
            state_next       = idle_state;
            token_begin_next = idle_begin;
          end
        end
        default: begin
          r0               = idle_res;
          n                = idle_has ? 2'd1 : 2'd0;
          state_next       = idle_state;
          token_begin_next = idle_begin;
        end
      endcase
      if (fail_code != ERR_NONE) begin
        fail_res.error_code = fail_code;
        r0                  = fail_res;
        n                   = 2'd1;
        state_next          = ST_ERR;
      end
    end

    r0.last_of_run = (n == 2'd1);
    r1.last_of_run = 1'b1;
  end

  assign push.count  = take ? n : 2'd0;
  assign push.first  = r0;
  assign push.second = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      pos         <= '0;
      token_begin <= '0;
    end else if (take) begin
      state       <= state_next;
      pos         <= pos_next;
      token_begin <= token_begin_next;
    end
  end

endmodule

`default_nettype wire

[rtl/jbt_fifo.sv]
// ----------------------------------------------------------------------------
// jbt_fifo
// Four-entry result queue: takes up to two words per cycle, sends one.
// ----------------------------------------------------------------------------
`default_nettype none

module jbt_fifo (
  input  logic           clk,
  input  logic           rst,
  input  jbt_pkg::push_t push,
  output logic           room,
  jbt_stream_if.source   out_ch
);
  import jbt_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  tok_word_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count, count_next;
  logic             pop;

  assign pop          = out_ch.valid && out_ch.ready;
  assign out_ch.valid = (count != '0);
  assign out_ch.data  = mem[rd_ptr];
  // Room for a two-word result, from registered state only
  assign room         = (count <= CNT_W'(DEPTH - 2));

  assign count_next = count + CNT_W'(push.count) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wr_ptr] <= push.first;
    if (push.count == 2'd2) mem[wr_ptr + 1'b1] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count_next;
    end
  end

endmodule

`default_nettype wire

[rtl/json_byte_tokenizer.sv]
// ----------------------------------------------------------------------------
// json_byte_tokenizer
// Streaming JSON lexer: one byte word in, token words out.
// ----------------------------------------------------------------------------
// A result word is written into the result queue as its byte is accepted and is offered from there.
// Throughput: one byte per cycle while the queue has room for two words;
//   a byte that yields two tokens puts both words into a four-entry queue.
// Reset (rst, synchronous): lexer idle, position and token start zero, queue
//   empty.
`default_nettype none

module json_byte_tokenizer #(
  parameter int unsigned MAX_BYTES = 65535
) (
  input  logic       clk,
  input  logic       rst,
  jbt_stream_if.sink   byte_in,
  jbt_stream_if.source token_out
);
  import jbt_pkg::*;

  in_word_t word;
  push_t    push;
  logic     room;
  logic     take;

  assign word          = byte_in.data;
  assign byte_in.ready = room;
  assign take          = byte_in.valid && room;

  jbt_lexer #(
    .MAX_BYTES (MAX_BYTES)
  ) u_lexer (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .word (word),
    .push (push)
  );

  jbt_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .room   (room),
    .out_ch (token_out)
  );

endmodule

`default_nettype wire
